FILE: hw/rtl/c2dvc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 2D valid correlation block.
// Depends on nothing; imported by every module of the block.
package c2dvc_pkg;

   localparam int SAMPLE_W        = 16;
   localparam int PRODUCT_W       = 32;
   localparam int RESULT_W        = 40;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 11;
   localparam int MAX_SOURCE_ROWS = 1024;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_ROWS    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_COLS    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_ROWS    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_COLS    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REVERSE_KERNEL = 3'd4;

   // register reset values
   localparam logic [3:0]  RST_KERNEL_ROWS = 4'd3;
   localparam logic [3:0]  RST_KERNEL_COLS = 4'd3;
   localparam logic [10:0] RST_SOURCE_ROWS = 11'd128;
   localparam logic [7:0]  RST_SOURCE_COLS = 8'd128;

   // request operation codes
   localparam logic OP_LOAD_COEFF = 1'b0;
   localparam logic OP_SAMPLE     = 1'b1;

   typedef struct packed {
      logic                       operation;
      logic signed [SAMPLE_W-1:0] sample_value;
   } c2dvc_req_type;

   typedef struct packed {
      logic signed [RESULT_W-1:0] result_value;
      logic                       last_result;
   } c2dvc_rsp_type;

   // sequencer to store/MAC command group
   typedef struct packed {
      logic kernel_we;
      logic line_we;
      logic read_en;
      logic read_first;
      logic read_last;
      logic result_load;
      logic result_last;
   } c2dvc_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_HOLD
   } c2dvc_state_type;

endpackage

FILE: hw/rtl/c2dvc_store.sv
`timescale 1ns / 1ps
// Kernel and line memories with the shared multiply-accumulate pipeline.
// Depends on c2dvc_pkg; driven by c2dvc_ctrl.
module c2dvc_store
   import c2dvc_pkg::*;
#(
   parameter int MAX_KERNEL_ROWS = 8,
   parameter int MAX_KERNEL_COLS = 8,
   parameter int MAX_SOURCE_COLS = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  c2dvc_cmd_type                        cmd,
   input  logic signed [SAMPLE_W-1:0]           sample_value,
   input  logic [((MAX_KERNEL_ROWS*MAX_KERNEL_COLS > 1) ?
                  $clog2(MAX_KERNEL_ROWS*MAX_KERNEL_COLS) : 1)-1:0] kernel_waddr,
   input  logic [((MAX_KERNEL_ROWS*MAX_KERNEL_COLS > 1) ?
                  $clog2(MAX_KERNEL_ROWS*MAX_KERNEL_COLS) : 1)-1:0] kernel_raddr,
   input  logic [$clog2(MAX_KERNEL_ROWS*MAX_SOURCE_COLS)-1:0]      line_waddr,
   input  logic [$clog2(MAX_KERNEL_ROWS*MAX_SOURCE_COLS)-1:0]      line_raddr,
   output logic                                 acc_done,
   output c2dvc_rsp_type                        rsp_data
);

   localparam int KDEPTH = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
   localparam int LDEPTH = MAX_KERNEL_ROWS * MAX_SOURCE_COLS;

   logic signed [SAMPLE_W-1:0]  kernel_mem [KDEPTH];
   logic signed [SAMPLE_W-1:0]  line_mem [LDEPTH];

   logic signed [SAMPLE_W-1:0]  kdata_ff;
   logic signed [SAMPLE_W-1:0]  ldata_ff;
   logic signed [PRODUCT_W-1:0] product_ff;
   logic signed [RESULT_W-1:0]  acc_ff;
   logic                        rd_valid_ff, rd_first_ff, rd_last_ff;
   logic                        mul_valid_ff, mul_first_ff, mul_last_ff;
   logic                        done_ff;
   c2dvc_rsp_type               rsp_ff;

   // memory ports: one write and one registered read each
   always_ff @(posedge clock) begin
      if (cmd.kernel_we) begin
         kernel_mem[kernel_waddr] <= sample_value;
      end
      if (cmd.line_we) begin
         line_mem[line_waddr] <= sample_value;
      end
      if (cmd.read_en) begin
         kdata_ff <= kernel_mem[kernel_raddr];
         ldata_ff <= line_mem[line_raddr];
      end
   end

   // pipeline flags
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         rd_first_ff  <= 1'b0;
         rd_last_ff   <= 1'b0;
         mul_valid_ff <= 1'b0;
         mul_first_ff <= 1'b0;
         mul_last_ff  <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         rd_valid_ff  <= cmd.read_en;
         rd_first_ff  <= cmd.read_first;
         rd_last_ff   <= cmd.read_last;
         mul_valid_ff <= rd_valid_ff;
         mul_first_ff <= rd_first_ff;
         mul_last_ff  <= rd_last_ff;
         done_ff      <= mul_valid_ff && mul_last_ff;
      end
   end

   // multiply, then accumulate
   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         product_ff <= kdata_ff * ldata_ff;
      end
      if (mul_valid_ff) begin
         if (mul_first_ff) begin
            acc_ff <= RESULT_W'(product_ff);
         end else begin
            acc_ff <= acc_ff + RESULT_W'(product_ff);
         end
      end
      if (cmd.result_load) begin
         rsp_ff.result_value <= acc_ff;
         rsp_ff.last_result  <= cmd.result_last;
      end
   end

   assign acc_done = done_ff;
   assign rsp_data = rsp_ff;

endmodule

FILE: hw/rtl/c2dvc_ctrl.sv
`timescale 1ns / 1ps
// Configuration registers, frame counters and window sequencer.
// Depends on c2dvc_pkg; commands c2dvc_store.
module c2dvc_ctrl
   import c2dvc_pkg::*;
#(
   parameter int MAX_KERNEL_ROWS = 8,
   parameter int MAX_KERNEL_COLS = 8,
   parameter int MAX_SOURCE_COLS = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [CSR_INDEX_W-1:0]               csr_index,
   input  logic [CSR_DATA_W-1:0]                csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_operation,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic                                 acc_done,
   output c2dvc_cmd_type                        cmd,
   output logic [((MAX_KERNEL_ROWS*MAX_KERNEL_COLS > 1) ?
                  $clog2(MAX_KERNEL_ROWS*MAX_KERNEL_COLS) : 1)-1:0] kernel_waddr,
   output logic [((MAX_KERNEL_ROWS*MAX_KERNEL_COLS > 1) ?
                  $clog2(MAX_KERNEL_ROWS*MAX_KERNEL_COLS) : 1)-1:0] kernel_raddr,
   output logic [$clog2(MAX_KERNEL_ROWS*MAX_SOURCE_COLS)-1:0]      line_waddr,
   output logic [$clog2(MAX_KERNEL_ROWS*MAX_SOURCE_COLS)-1:0]      line_raddr
);

   localparam int KDEPTH = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
   localparam int LDEPTH = MAX_KERNEL_ROWS * MAX_SOURCE_COLS;
   localparam int KIW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
   localparam int KSW    = $clog2(KDEPTH + 1);
   localparam int LAW    = $clog2(LDEPTH);
   localparam int KRW    = $clog2(MAX_KERNEL_ROWS + 1);
   localparam int KCW    = $clog2(MAX_KERNEL_COLS + 1);
   localparam int SCW    = $clog2(MAX_SOURCE_COLS + 1);
   localparam int CW     = $clog2(MAX_SOURCE_COLS);
   localparam int LRW    = (MAX_KERNEL_ROWS > 1) ? $clog2(MAX_KERNEL_ROWS) : 1;
   localparam int LAST_BASE = (MAX_KERNEL_ROWS - 1) * MAX_SOURCE_COLS;

   logic [3:0]      kernel_rows_ff, kernel_rows_in;
   logic [3:0]      kernel_cols_ff, kernel_cols_in;
   logic [10:0]     source_rows_ff, source_rows_in;
   logic [7:0]      source_cols_ff, source_cols_in;
   logic            reverse_ff, reverse_in;

   c2dvc_state_type state_ff, state_in;
   logic [KIW-1:0]  kwi_ff, kwi_in;
   logic [9:0]      row_ff, row_in;
   logic [CW-1:0]   col_ff, col_in;
   logic [LRW-1:0]  lrow_ff, lrow_in;
   logic [LAW-1:0]  base_ff, base_in;
   logic [CW-1:0]   left_ff, left_in;
   logic [KCW-1:0]  kcol_ff, kcol_in;
   logic [KIW-1:0]  ki_ff, ki_in;
   logic            last_ff, last_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic [KRW-1:0]  kr_c;
   logic [KCW-1:0]  kc_c;
   logic [10:0]     sr_c;
   logic [SCW-1:0]  sc_c;
   logic [KSW-1:0]  ksize;

   // clamp the registers to their usable ranges
   always_comb begin
      if (kernel_rows_ff == 4'd0) kr_c = KRW'(1);
      else if (32'(kernel_rows_ff) > MAX_KERNEL_ROWS) kr_c = KRW'(MAX_KERNEL_ROWS);
      else kr_c = KRW'(kernel_rows_ff);

      if (kernel_cols_ff == 4'd0) kc_c = KCW'(1);
      else if (32'(kernel_cols_ff) > MAX_KERNEL_COLS) kc_c = KCW'(MAX_KERNEL_COLS);
      else kc_c = KCW'(kernel_cols_ff);

      if (source_rows_ff == 11'd0) sr_c = 11'd1;
      else if (32'(source_rows_ff) > MAX_SOURCE_ROWS) sr_c = 11'(MAX_SOURCE_ROWS);
      else sr_c = source_rows_ff;

      if (source_cols_ff == 8'd0) sc_c = SCW'(1);
      else if (32'(source_cols_ff) > MAX_SOURCE_COLS) sc_c = SCW'(MAX_SOURCE_COLS);
      else sc_c = SCW'(source_cols_ff);

      ksize = KSW'(32'(kr_c) * 32'(kc_c));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_rows_ff <= RST_KERNEL_ROWS;
         kernel_cols_ff <= RST_KERNEL_COLS;
         source_rows_ff <= RST_SOURCE_ROWS;
         source_cols_ff <= RST_SOURCE_COLS;
         reverse_ff     <= 1'b0;
         state_ff       <= ST_IDLE;
         kwi_ff         <= '0;
         row_ff         <= '0;
         col_ff         <= '0;
         lrow_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         kernel_rows_ff <= kernel_rows_in;
         kernel_cols_ff <= kernel_cols_in;
         source_rows_ff <= source_rows_in;
         source_cols_ff <= source_cols_in;
         reverse_ff     <= reverse_in;
         state_ff       <= state_in;
         kwi_ff         <= kwi_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
         lrow_ff        <= lrow_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // window sequencing registers
   always_ff @(posedge clock) begin
      base_ff <= base_in;
      left_ff <= left_in;
      kcol_ff <= kcol_in;
      ki_ff   <= ki_in;
      last_ff <= last_in;
   end

   always_comb begin
      logic [KIW-1:0] kidx;
      logic [KSW-1:0] knext;
      logic [KSW-1:0] kread;
      logic           oor;
      logic [9:0]     row;
      logic [CW-1:0]  col;
      logic [LRW-1:0] lrow;
      logic           window;
      logic           frame_last;
      logic           out_free;
      int             top;

      kernel_rows_in = kernel_rows_ff;
      kernel_cols_in = kernel_cols_ff;
      source_rows_in = source_rows_ff;
      source_cols_in = source_cols_ff;
      reverse_in     = reverse_ff;
      state_in       = state_ff;
      kwi_in         = kwi_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      lrow_in        = lrow_ff;
      base_in        = base_ff;
      left_in        = left_ff;
      kcol_in        = kcol_ff;
      ki_in          = ki_ff;
      last_in        = last_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      out_free       = !rsp_valid_ff || rsp_ready;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      // coefficient write slot
      kidx  = (KSW'(kwi_ff) >= ksize) ? '0 : kwi_ff;
      knext = KSW'(kidx) + KSW'(1);
      kernel_waddr = kidx;

      // sample position, restarted when the counters fall outside the frame
      oor  = (32'(row_ff) >= 32'(sr_c)) || (32'(col_ff) >= 32'(sc_c));
      row  = oor ? '0 : row_ff;
      col  = oor ? '0 : col_ff;
      lrow = oor ? '0 : lrow_ff;
      line_waddr = LAW'(32'(lrow) * MAX_SOURCE_COLS + 32'(col));
      window = (32'(kr_c) <= 32'(sr_c)) && (32'(kc_c) <= 32'(sc_c)) &&
               (32'(row) + 1 >= 32'(kr_c)) && (32'(col) + 1 >= 32'(kc_c));
      frame_last = (32'(row) + 1 == 32'(sr_c)) && (32'(col) + 1 == 32'(sc_c));
      top = int'(lrow) - int'(kr_c) + 1;
      if (top < 0) begin
         top = top + MAX_KERNEL_ROWS;
      end

      // read addresses for the current tap
      kread = reverse_ff ? (ksize - KSW'(1) - KSW'(ki_ff)) : KSW'(ki_ff);
      kernel_raddr = KIW'(kread);
      line_raddr   = base_ff + LAW'(left_ff) + LAW'(kcol_ff);

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_operation == OP_LOAD_COEFF) begin
                  cmd.kernel_we = 1'b1;
                  kwi_in = (knext >= ksize) ? '0 : KIW'(knext);
               end else begin
                  cmd.line_we = 1'b1;
                  // advance the frame position
                  if (32'(col) + 1 >= 32'(sc_c)) begin
                     col_in = '0;
                     if (32'(row) + 1 >= 32'(sr_c)) begin
                        row_in  = '0;
                        lrow_in = '0;
                     end else begin
                        row_in  = row + 10'd1;
                        lrow_in = (32'(lrow) == MAX_KERNEL_ROWS - 1) ? '0 : lrow + LRW'(1);
                     end
                  end else begin
                     col_in  = col + CW'(1);
                     row_in  = row;
                     lrow_in = lrow;
                  end
                  if (window) begin
                     base_in  = LAW'(top * MAX_SOURCE_COLS);
                     left_in  = CW'(32'(col) + 1 - 32'(kc_c));
                     kcol_in  = '0;
                     ki_in    = '0;
                     last_in  = frame_last;
                     state_in = ST_ISSUE;
                  end
               end
            end
         end
         ST_ISSUE: begin
            cmd.read_en    = 1'b1;
            cmd.read_first = (ki_ff == '0);
            cmd.read_last  = (KSW'(ki_ff) == ksize - KSW'(1));
            ki_in = ki_ff + KIW'(1);
            if (32'(kcol_ff) + 1 >= 32'(kc_c)) begin
               kcol_in = '0;
               base_in = (32'(base_ff) == LAST_BASE) ? '0 : base_ff + LAW'(MAX_SOURCE_COLS);
            end else begin
               kcol_in = kcol_ff + KCW'(1);
            end
            if (cmd.read_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (acc_done) begin
               if (out_free) begin
                  cmd.result_load = 1'b1;
                  cmd.result_last = last_ff;
                  rsp_valid_in    = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.result_load = 1'b1;
               cmd.result_last = last_ff;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // any register write restarts the frame and the kernel load
      if (csr_we) begin
         unique case (csr_index)
            CSR_KERNEL_ROWS:    kernel_rows_in = csr_wdata[3:0];
            CSR_KERNEL_COLS:    kernel_cols_in = csr_wdata[3:0];
            CSR_SOURCE_ROWS:    source_rows_in = csr_wdata;
            CSR_SOURCE_COLS:    source_cols_in = csr_wdata[7:0];
            CSR_REVERSE_KERNEL: reverse_in     = csr_wdata[0];
            default: begin
            end
         endcase
         kwi_in  = '0;
         row_in  = '0;
         col_in  = '0;
         lrow_in = '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hw/rtl/conv2d_valid_correlate.sv
`timescale 1ns / 1ps
// Top level of the streaming 2D valid correlation / convolution block.
// Depends on c2dvc_pkg, c2dvc_ctrl and c2dvc_store.
//
// Usage:
//   Program the registers through the csr_ port while idle; every write,
//   whatever its index, restarts the frame and the kernel load position.
//   Send r*c coefficients (operation 0) in row-major order, then stream
//   source samples (operation 1) in row-major order on the req_ channel.
//   Each sample that completes a kernel window gives one request on the
//   rsp_ channel, in row-major window order; last_result marks the final
//   window of the frame.
// Timing:
//   A coefficient, or a sample that completes no window, leaves the block
//   idle and ready for the next request. A sample that completes a window
//   keeps the block busy while the single shared multiply-accumulate reads
//   one kernel/line pair per cycle from the two memories, then drains a
//   three-stage pipeline.
// Reset and stall:
//   Reset clears counters and restores r=3, c=3, R=128, C=128, correlation.
//   Memory contents are not cleared. A held result waits in the output
//   register; the next request is still taken, and a new result then
//   holds in the accumulator until the receiver drains the first one.
module conv2d_valid_correlate
   import c2dvc_pkg::*;
#(
   parameter int MAX_KERNEL_ROWS = 8,
   parameter int MAX_KERNEL_COLS = 8,
   parameter int MAX_SOURCE_COLS = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  c2dvc_req_type          req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output c2dvc_rsp_type          rsp_payload
);

   localparam int KDEPTH = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
   localparam int KIW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
   localparam int LAW    = $clog2(MAX_KERNEL_ROWS * MAX_SOURCE_COLS);

   c2dvc_cmd_type  cmd;
   logic           acc_done;
   logic [KIW-1:0] kernel_waddr, kernel_raddr;
   logic [LAW-1:0] line_waddr, line_raddr;

   // sequencer: registers, frame counters, tap addressing
   c2dvc_ctrl #(
      .MAX_KERNEL_ROWS (MAX_KERNEL_ROWS),
      .MAX_KERNEL_COLS (MAX_KERNEL_COLS),
      .MAX_SOURCE_COLS (MAX_SOURCE_COLS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_payload.operation),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .acc_done      (acc_done),
      .cmd           (cmd),
      .kernel_waddr  (kernel_waddr),
      .kernel_raddr  (kernel_raddr),
      .line_waddr    (line_waddr),
      .line_raddr    (line_raddr)
   );

   // memories and the shared MAC; also holds the result register
   c2dvc_store #(
      .MAX_KERNEL_ROWS (MAX_KERNEL_ROWS),
      .MAX_KERNEL_COLS (MAX_KERNEL_COLS),
      .MAX_SOURCE_COLS (MAX_SOURCE_COLS)
   ) u_store (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sample_value (req_payload.sample_value),
      .kernel_waddr (kernel_waddr),
      .kernel_raddr (kernel_raddr),
      .line_waddr   (line_waddr),
      .line_raddr   (line_raddr),
      .acc_done     (acc_done),
      .rsp_data     (rsp_payload)
   );

endmodule

FILE: verif/c2dvc_checker.sv
`timescale 1ns / 1ps
// Checker for conv2d_valid_correlate: follows register writes and requests,
// predicts each window sum and compares it with every rsp_ request.
// Depends on c2dvc_pkg only.
module c2dvc_checker
   import c2dvc_pkg::*;
#(
   parameter int MAX_KERNEL_ROWS = 8,
   parameter int MAX_KERNEL_COLS = 8,
   parameter int MAX_SOURCE_COLS = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  c2dvc_req_type          req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  c2dvc_rsp_type          rsp_payload,
   output int                     failures,
   output int                     sums_pending
);

   localparam int KERNEL_DEPTH = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
   localparam int LINE_DEPTH   = MAX_KERNEL_ROWS * MAX_SOURCE_COLS;

   logic [3:0]  kernel_rows;
   logic [3:0]  kernel_cols;
   logic [10:0] source_rows;
   logic [7:0]  source_cols;
   logic        reverse_kernel;

   logic signed [SAMPLE_W-1:0] coeffs [KERNEL_DEPTH];
   logic signed [SAMPLE_W-1:0] lines  [LINE_DEPTH];
   int unsigned                coeff_index;
   int unsigned                row_pos;
   int unsigned                col_pos;

   c2dvc_rsp_type window_sums_due [$];

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // any write, known index or not, restarts the frame and the kernel load
   function automatic void apply_register(logic [CSR_INDEX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_KERNEL_ROWS:    kernel_rows = data[3:0];
         CSR_KERNEL_COLS:    kernel_cols = data[3:0];
         CSR_SOURCE_ROWS:    source_rows = data[10:0];
         CSR_SOURCE_COLS:    source_cols = data[7:0];
         CSR_REVERSE_KERNEL: reverse_kernel = data[0];
         default: ;
      endcase
      coeff_index = 0;
      row_pos = 0;
      col_pos = 0;
   endfunction

   function automatic void correlate_request(c2dvc_req_type rq);
      int unsigned   kr, kc, sr, sc, ksize, row, col, top, left, ki;
      longint        acc;
      c2dvc_rsp_type sum;
      kr = clamp_dim(kernel_rows, MAX_KERNEL_ROWS);
      kc = clamp_dim(kernel_cols, MAX_KERNEL_COLS);
      sr = clamp_dim(source_rows, MAX_SOURCE_ROWS);
      sc = clamp_dim(source_cols, MAX_SOURCE_COLS);
      ksize = kr * kc;
      if (rq.operation == OP_LOAD_COEFF) begin
         if (coeff_index >= ksize) coeff_index = 0;
         coeffs[coeff_index] = rq.sample_value;
         coeff_index++;
         if (coeff_index >= ksize) coeff_index = 0;
         return;
      end
      row = row_pos;
      col = col_pos;
      if (row >= sr || col >= sc) begin
         row = 0;
         col = 0;
      end
      lines[(row % MAX_KERNEL_ROWS) * MAX_SOURCE_COLS + col] = rq.sample_value;
      if (kr <= sr && kc <= sc && row + 1 >= kr && col + 1 >= kc) begin
         acc = 0;
         top = row + 1 - kr;
         left = col + 1 - kc;
         for (int k = 0; k < kr; k++) begin
            for (int l = 0; l < kc; l++) begin
               ki = k * kc + l;
               if (reverse_kernel) ki = ksize - 1 - ki;
               acc += longint'(coeffs[ki]) *
                      longint'(lines[((top + k) % MAX_KERNEL_ROWS) * MAX_SOURCE_COLS
                                     + left + l]);
            end
         end
         sum.result_value = acc[RESULT_W-1:0];
         sum.last_result = (row == sr - 1 && col == sc - 1);
         window_sums_due.push_back(sum);
      end
      col++;
      if (col >= sc) begin
         col = 0;
         row++;
         if (row >= sr) row = 0;
      end
      row_pos = row;
      col_pos = col;
   endfunction

   always @(posedge clock) begin : watch
      c2dvc_rsp_type due;
      if (reset) begin
         kernel_rows = RST_KERNEL_ROWS;
         kernel_cols = RST_KERNEL_COLS;
         source_rows = RST_SOURCE_ROWS;
         source_cols = RST_SOURCE_COLS;
         reverse_kernel = 1'b0;
         coeff_index = 0;
         row_pos = 0;
         col_pos = 0;
         window_sums_due.delete();
      end else begin
         if (csr_we) apply_register(csr_index, csr_wdata);
         if (rsp_valid && rsp_ready) begin
            if (window_sums_due.size() == 0) begin
               failures++;
               $display("%0t: unexpected result, actual %h", $time, rsp_payload);
            end else begin
               due = window_sums_due.pop_front();
               if (rsp_payload.result_value !== due.result_value) begin
                  failures++;
                  $display("%0t: result_value expected %h actual %h", $time,
                           due.result_value, rsp_payload.result_value);
               end
               if (rsp_payload.last_result !== due.last_result) begin
                  failures++;
                  $display("%0t: last_result expected %b actual %b", $time,
                           due.last_result, rsp_payload.last_result);
               end
            end
         end
         if (req_valid && req_ready) correlate_request(req_payload);
      end
      sums_pending = window_sums_due.size();
   end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Top of the conv2d_valid_correlate regression: clock, reset, register
// writes, request stimulus and rsp_ back-pressure, plus the verdict.
// Depends on c2dvc_pkg, c2dvc_checker and the block under test.
module tb;
   import c2dvc_pkg::*;

   localparam int MAX_KERNEL_ROWS = 8;
   localparam int MAX_KERNEL_COLS = 8;
   localparam int MAX_SOURCE_COLS = 128;
   localparam int RANDOM_REQUESTS = 1250;
   localparam int MAX_GAP         = 14;
   // long enough for a window of the largest kernel, with margin on top
   localparam int DRAIN_CYCLES    = MAX_KERNEL_ROWS * MAX_KERNEL_COLS + 16;
   localparam int TIMEOUT_NS      = 20_000_000;

   // indexes past the register list: the write is dropped but still restarts
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LAST  = 3'd7;

   localparam logic signed [SAMPLE_W-1:0] Q88_MIN = 16'sh8000;
   localparam logic signed [SAMPLE_W-1:0] Q88_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] Q88_ONE = 16'sh0100;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   c2dvc_req_type          req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   c2dvc_rsp_type          rsp_payload;

   int failures;
   int sums_pending;
   int requests_sent = 0;
   // set for a whole phase: neither side idles while it holds
   bit calm = 1'b0;

   conv2d_valid_correlate #(
      .MAX_KERNEL_ROWS(MAX_KERNEL_ROWS),
      .MAX_KERNEL_COLS(MAX_KERNEL_COLS),
      .MAX_SOURCE_COLS(MAX_SOURCE_COLS)
   ) DUT (.*);

   c2dvc_checker #(
      .MAX_KERNEL_ROWS(MAX_KERNEL_ROWS),
      .MAX_KERNEL_COLS(MAX_KERNEL_COLS),
      .MAX_SOURCE_COLS(MAX_SOURCE_COLS)
   ) u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("conv2d_valid_correlate regression: fail");
      $finish;
   end

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // mostly in range, now and then zero or past the top so the clamp is hit
   function automatic logic [3:0] draw_kernel_dim(int unsigned hi);
      case ($urandom_range(0, 11))
         0: return 4'd0;
         1: return 4'($urandom_range(9, 15));
         default: return 4'($urandom_range(1, hi));
      endcase
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] draw_q88();
      case ($urandom_range(0, 9))
         0: return Q88_MIN;
         1: return Q88_MAX;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Offer one request after a random gap. Lower valid only inside the gap,
   // so that back-to-back requests keep it high without a second assignment.
   task automatic send_request(input logic op, input logic signed [SAMPLE_W-1:0] value);
      int gap;
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{operation: op, sample_value: value};
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // Drop valid, wait for every predicted sum to arrive, then give the block
   // time to finish a sample that completes no window.
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sums_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Drive the write and wait for a clock edge; the caller lowers csr_we after the group.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // One random phase: fresh registers, a full kernel, then one or more
   // frames of samples (or a slice of a large frame) with stray coefficient
   // loads mixed in.
   task automatic run_random_phase();
      logic [3:0]  rows_nib, cols_nib;
      logic [10:0] rows_raw;
      logic [7:0]  cols_raw;
      bit          dirty;
      int unsigned kr, kc, sr, sc, frame, samples;
      rows_nib = draw_kernel_dim(MAX_KERNEL_ROWS);
      cols_nib = draw_kernel_dim(MAX_KERNEL_COLS);
      kr = clamp_dim(rows_nib, MAX_KERNEL_ROWS);
      kc = clamp_dim(cols_nib, MAX_KERNEL_COLS);
      // most sources just cover the kernel, so windows come often
      case ($urandom_range(0, 9))
         0: rows_raw = 11'(MAX_SOURCE_ROWS);
         1: rows_raw = ($urandom_range(0, 1) != 0) ? 11'd0 : 11'($urandom_range(1025, 2047));
         2: rows_raw = 11'($urandom_range(1, 40));
         default: rows_raw = 11'(kr + $urandom_range(0, 4));
      endcase
      case ($urandom_range(0, 9))
         0: cols_raw = 8'(MAX_SOURCE_COLS);
         1: cols_raw = ($urandom_range(0, 1) != 0) ? 8'd0 : 8'($urandom_range(129, 255));
         2: cols_raw = 8'($urandom_range(1, 20));
         default: cols_raw = 8'(kc + $urandom_range(0, 4));
      endcase
      sr = clamp_dim(rows_raw, MAX_SOURCE_ROWS);
      sc = clamp_dim(cols_raw, MAX_SOURCE_COLS);
      // junk in the bits above each register's width must be ignored
      dirty = ($urandom_range(0, 3) == 0);

      settle();
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0)
         write_register(CSR_INDEX_W'($urandom_range(CSR_SPARE_FIRST, CSR_SPARE_LAST)),
                        CSR_DATA_W'($urandom));
      write_register(CSR_KERNEL_ROWS, {dirty ? 7'($urandom) : 7'd0, rows_nib});
      write_register(CSR_KERNEL_COLS, {dirty ? 7'($urandom) : 7'd0, cols_nib});
      write_register(CSR_SOURCE_ROWS, rows_raw);
      write_register(CSR_SOURCE_COLS, {dirty ? 3'($urandom) : 3'd0, cols_raw});
      write_register(CSR_REVERSE_KERNEL,
                     {dirty ? 10'($urandom) : 10'd0, 1'($urandom)});
      csr_we <= 1'b0;

      // load the whole kernel before any window can read it
      for (int i = 0; i < kr * kc; i++) send_request(OP_LOAD_COEFF, draw_q88());

      frame = sr * sc;
      if (frame <= 200)
         samples = frame * $urandom_range(1, 2) +
                   (($urandom_range(0, 3) == 0) ? $urandom_range(1, frame) : 0);
      else
         samples = $urandom_range(10, 150);
      for (int i = 0; i < samples; i++) begin
         // a stray coefficient mid-frame overwrites an entry already loaded
         if ($urandom_range(0, 24) == 0) send_request(OP_LOAD_COEFF, draw_q88());
         send_request(OP_SAMPLE, draw_q88());
      end
   endtask

   // rsp_ side: stall a random number of cycles before each result
   initial begin : drain_results
      int hold;
      @(negedge reset);
      forever begin
         hold = calm ? 0 : $urandom_range(0, MAX_GAP);
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin : stimulus
      int random_base;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Kernel stays at its 3x3 reset size while the source shrinks to 2x2:
      // the frame runs its four samples and gives no window at all.
      settle();
      write_register(CSR_SOURCE_ROWS, 11'd2);
      write_register(CSR_SOURCE_COLS, 11'd2);
      csr_we <= 1'b0;
      send_request(OP_SAMPLE, Q88_MIN);
      send_request(OP_SAMPLE, Q88_MAX);
      send_request(OP_SAMPLE, 16'sh0000);
      send_request(OP_SAMPLE, -16'sh0001);

      // Kernel rows written as zero with junk above the nibble clamp to one,
      // source rows of 2047 clamp to 1024. Five loads into a 1x2 kernel wrap
      // twice and leave the load position at the second entry.
      settle();
      write_register(CSR_KERNEL_ROWS, 11'h7f0);
      write_register(CSR_KERNEL_COLS, 11'd2);
      write_register(CSR_SOURCE_ROWS, 11'h7ff);
      csr_we <= 1'b0;
      send_request(OP_LOAD_COEFF, Q88_MAX);
      send_request(OP_LOAD_COEFF, Q88_MIN);
      send_request(OP_LOAD_COEFF, Q88_ONE);
      send_request(OP_LOAD_COEFF, Q88_MIN);
      send_request(OP_LOAD_COEFF, Q88_MIN);
      send_request(OP_SAMPLE, Q88_MIN);
      send_request(OP_SAMPLE, Q88_MIN);
      send_request(OP_SAMPLE, Q88_MAX);
      send_request(OP_SAMPLE, Q88_MAX);

      // A write past the register list must still restart the frame and the
      // load position: the next coefficient lands in the first entry.
      settle();
      write_register(CSR_SPARE_FIRST + 3'd1, 11'h555);
      csr_we <= 1'b0;
      send_request(OP_LOAD_COEFF, Q88_ONE);
      send_request(OP_SAMPLE, Q88_MAX);
      send_request(OP_SAMPLE, Q88_MIN);

      // Flip the kernel and shrink to two rows so the frame end is flagged.
      settle();
      write_register(CSR_REVERSE_KERNEL, 11'd1);
      write_register(CSR_SOURCE_ROWS, 11'd2);
      csr_we <= 1'b0;
      send_request(OP_SAMPLE, Q88_MAX);
      send_request(OP_SAMPLE, Q88_MIN);
      send_request(OP_SAMPLE, 16'sh1234);
      send_request(OP_SAMPLE, -16'sh4321);

      random_base = requests_sent;
      while (requests_sent - random_base < RANDOM_REQUESTS) run_random_phase();

      settle();
      if (failures == 0)
         $display("conv2d_valid_correlate regression: pass");
      else
         $display("conv2d_valid_correlate regression: fail");
      $finish;
   end

endmodule
